>>> design/snow_slope_redistribution_rate_macros.svh
// Assertion macros shared by the snow slope redistribution rate RTL.
`ifndef SNOW_SLOPE_REDISTRIBUTION_RATE_MACROS_SVH
`define SNOW_SLOPE_REDISTRIBUTION_RATE_MACROS_SVH

// Same-cycle implication.
`define SSR_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SSR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ssr_pkg.sv
// Types, constants and table functions of the snow slope redistribution rate block.
`default_nettype none

package ssr_pkg;

   localparam int SLOPE_W     = 15;
   localparam int SWE_W       = 20;
   localparam int WEIGHT_W    = 16;
   localparam int AREA_W      = 24;
   localparam int AREA_SC_W   = 35;
   localparam int RATE_W      = 48;
   localparam int MAX_W       = 20;
   localparam int TS_W        = 11;
   localparam int F1_W        = 16;
   localparam int F2_QW       = 16;
   localparam int REQ_DATA_W  = 80;
   localparam int RSP_DATA_W  = 72;
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 20;

   localparam int EXP_TABLE_DEPTH = 64;

   localparam logic [CSR_ADDR_W-1:0] REG_METHOD   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX      = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_TIMESTEP = 2'd2;

   localparam logic             METHOD_RESET   = 1'b0;
   localparam logic [MAX_W-1:0] MAX_RESET      = 20'd100000;
   localparam logic [TS_W-1:0]  TIMESTEP_RESET = 11'd1440;

   localparam logic [15:0]        INV_TAN80_Q   = 16'd46223;
   localparam logic [SLOPE_W-1:0] SLOPE_60DEG   = 15'd17157;
   localparam int                 INV_60DEG_Q32 = 250329;
   localparam logic [F1_W-1:0]    HALF_Q16      = 16'd32768;
   localparam logic [16:0]        ONE_Q16       = 17'd65536;
   localparam logic [10:0]        DAY_MINUTES   = 11'd1440;

   typedef struct packed {
      logic             method;
      logic [MAX_W-1:0] max_height;
      logic [TS_W-1:0]  timestep;
   } ssr_cfg_type;

   typedef struct packed {
      logic                 valid;
      logic [SWE_W-1:0]     moved;
      logic [WEIGHT_W-1:0]  weight;
      logic [AREA_SC_W-1:0] area_sc;
   } ssr_xfer_type;

   function automatic logic [63:0] exp_ratio(input logic [63:0] h);
      logic [63:0] term;
      logic [63:0] r;
      term = 64'd1 << 32;
      r    = 64'd1 << 32;
      term = ((term * h) >> 32) / 64'd1;  r = r - term;
      term = ((term * h) >> 32) / 64'd2;  r = r + term;
      term = ((term * h) >> 32) / 64'd3;  r = r - term;
      term = ((term * h) >> 32) / 64'd4;  r = r + term;
      term = ((term * h) >> 32) / 64'd5;  r = r - term;
      term = ((term * h) >> 32) / 64'd6;  r = r + term;
      term = ((term * h) >> 32) / 64'd7;  r = r - term;
      term = ((term * h) >> 32) / 64'd8;  r = r + term;
      term = ((term * h) >> 32) / 64'd9;  r = r - term;
      term = ((term * h) >> 32) / 64'd10; r = r + term;
      term = ((term * h) >> 32) / 64'd11; r = r - term;
      term = ((term * h) >> 32) / 64'd12; r = r + term;
      term = ((term * h) >> 32) / 64'd13; r = r - term;
      term = ((term * h) >> 32) / 64'd14; r = r + term;
      return r;
   endfunction

   function automatic logic [15:0] exp_entry(input logic [63:0] r, input int n);
      logic [63:0] v;
      logic [63:0] t;
      v = 64'd1 << 32;
      for (int j = 1; j <= n; j++) begin
         v = (v * r + (64'd1 << 31)) >> 32;
      end
      t = (v + (64'd1 << 15)) >> 16;
      return (t > 64'd65535) ? 16'hFFFF : t[15:0];
   endfunction

endpackage

`default_nettype wire

>>> design/snow_slope_redistribution_rate.sv
// Snow slope redistribution rate: top level with stream ports and register file.
//
// Takes one lateral connection per cycle and returns its moved snow depth and exchange
// rate through a 16-stage swe/max divider and a 48-stage rate divider, each resolving
// one quotient bit per stage. Requests stream in back to back; when a result is held
// on the response side the whole pipeline holds.
`default_nettype none

`include "snow_slope_redistribution_rate_macros.svh"

module snow_slope_redistribution_rate #(
   parameter int EXP_TABLE_DEPTH = ssr_pkg::EXP_TABLE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // slope_q14[14:0], snow_swe[34:15], conn_weight[50:35], area_from[74:51], zero fill
   input  wire logic [ssr_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // snow_moved[19:0], xfer_rate[67:20], zero fill
   output logic [ssr_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // rate_saturated[0]
   output logic                                  rsp_tuser,
   input  wire logic                             csr_we,
   input  wire logic [ssr_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  wire logic [ssr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ssr_pkg::ssr_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.method     <= ssr_pkg::METHOD_RESET;
         cfg_ff.max_height <= ssr_pkg::MAX_RESET;
         cfg_ff.timestep   <= ssr_pkg::TIMESTEP_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            ssr_pkg::REG_METHOD:   cfg_ff.method     <= csr_wdata[0];
            ssr_pkg::REG_MAX:      cfg_ff.max_height <= csr_wdata[ssr_pkg::MAX_W-1:0];
            ssr_pkg::REG_TIMESTEP: cfg_ff.timestep   <= csr_wdata[ssr_pkg::TS_W-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_tvalid_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   ssr_pkg::ssr_xfer_type xfer;

   ssr_moved #(
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_moved (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .slope_q14  (req_tdata[14:0]),
      .snow_swe   (req_tdata[34:15]),
      .conn_weight(req_tdata[50:35]),
      .area_from  (req_tdata[74:51]),
      .out_xfer   (xfer)
   );

   logic                             r_valid;
   logic [ssr_pkg::SWE_W-1:0]        r_moved;
   logic [ssr_pkg::RATE_W-1:0]       r_rate;
   logic                             r_sat;

   ssr_rate u_rate (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .timestep (cfg_ff.timestep),
      .in_xfer  (xfer),
      .out_valid(r_valid),
      .out_moved(r_moved),
      .out_rate (r_rate),
      .out_sat  (r_sat)
   );

   logic [ssr_pkg::SWE_W-1:0]  rsp_moved_ff;
   logic [ssr_pkg::RATE_W-1:0] rsp_rate_ff;
   logic                       rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= r_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_moved_ff <= r_moved;
         rsp_rate_ff  <= r_rate;
         rsp_sat_ff   <= r_sat;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {4'd0, rsp_rate_ff, rsp_moved_ff};
   assign rsp_tuser  = rsp_sat_ff;

   `SSR_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_tvalid_ff, "response valid after reset")
   `SSR_ASSERT_HOLDS(a_no_accept_frozen, clock, reset, req_tvalid && req_tready, !rsp_tvalid_ff || rsp_tready, "request taken while pipeline held")
   `SSR_ASSERT_HOLDS(a_sat_pins_rate, clock, reset, rsp_tvalid_ff && rsp_sat_ff, rsp_rate_ff == '1, "saturated rate not at maximum")

endmodule

`default_nettype wire

>>> design/ssr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`default_nettype none

`include "snow_slope_redistribution_rate_macros.svh"

module ssr_div #(
   parameter int QW = 16,
   parameter int DW = 20,
   parameter int SW = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_valid,
   input  wire logic [QW+DW-1:0] in_num,
   input  wire logic [DW-1:0] in_den,
   input  wire logic [SW-1:0] in_side,
   output logic               out_valid,
   output logic [QW-1:0]      out_quo,
   output logic [SW-1:0]      out_side
);

   logic          vld_ff  [QW];
   logic [DW-1:0] rem_ff  [QW];
   logic [QW-1:0] lo_ff   [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [SW-1:0] side_ff [QW];
   logic [DW-1:0] rem_in  [QW];
   logic [QW-1:0] lo_in   [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic          vld_src;
      logic [DW-1:0] rem_src;
      logic [QW-1:0] lo_src;
      logic [DW-1:0] den_src;
      logic [SW-1:0] side_src;
      logic [DW:0]   trial;
      logic          take;

      if (k == 0) begin : g_first
         assign vld_src  = in_valid;
         assign rem_src  = in_num[QW+DW-1:QW];
         assign lo_src   = in_num[QW-1:0];
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign vld_src  = vld_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign lo_src   = lo_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign trial     = {rem_src, lo_src[QW-1]};
      assign take      = trial >= {1'b0, den_src};
      assign rem_in[k] = take ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];
      assign lo_in[k]  = {lo_src[QW-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in[k];
            lo_ff[k]   <= lo_in[k];
            den_ff[k]  <= den_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = lo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

   `SSR_ASSERT_NEXT(a_div_stall_holds, clock, reset, !adv, $stable(out_valid) && $stable(out_quo), "divider output moved during stall")

endmodule

`default_nettype wire

>>> design/ssr_moved.sv
// Moved snow depth: continuous slope factor or threshold excess over interpolated exp.
`default_nettype none

module ssr_moved #(
   parameter int EXP_TABLE_DEPTH = ssr_pkg::EXP_TABLE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            adv,
   input  wire ssr_pkg::ssr_cfg_type            cfg,
   input  wire logic                            in_valid,
   input  wire logic [ssr_pkg::SLOPE_W-1:0]     slope_q14,
   input  wire logic [ssr_pkg::SWE_W-1:0]       snow_swe,
   input  wire logic [ssr_pkg::WEIGHT_W-1:0]    conn_weight,
   input  wire logic [ssr_pkg::AREA_W-1:0]      area_from,
   output ssr_pkg::ssr_xfer_type                out_xfer
);

   localparam int          IW        = $clog2(EXP_TABLE_DEPTH + 1);
   localparam logic [63:0] EXP_STEP  = (64'd3 << 32) / EXP_TABLE_DEPTH;
   localparam logic [63:0] EXP_RATIO = ssr_pkg::exp_ratio(EXP_STEP);
   localparam logic [31:0] POS_MUL   = 32'(EXP_TABLE_DEPTH * ssr_pkg::INV_60DEG_Q32);
   localparam int          POS_W     = ssr_pkg::SLOPE_W + $clog2(POS_MUL + 1);
   localparam int          SWE_W     = ssr_pkg::SWE_W;
   localparam int          F1_W      = ssr_pkg::F1_W;
   localparam int          WT_W      = ssr_pkg::WEIGHT_W;
   localparam int          AR_W      = ssr_pkg::AREA_SC_W;
   localparam int          SIDE_W    = SWE_W + F1_W + SWE_W + WT_W + AR_W;

   logic [15:0] exp_tab [EXP_TABLE_DEPTH+1];

   for (genvar i = 0; i <= EXP_TABLE_DEPTH; i++) begin : g_tab
      assign exp_tab[i] = ssr_pkg::exp_entry(EXP_RATIO, i);
   end

   // stage 1
   logic             v1_ff;
   logic [SWE_W-1:0] swe1_ff;
   logic [WT_W-1:0]  wt1_ff;
   logic [AR_W-1:0]  ar1_ff;
   logic [30:0]      cp1_ff;
   logic [POS_W-1:0] pos1_ff;
   logic             thz1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         swe1_ff <= snow_swe;
         wt1_ff  <= conn_weight;
         ar1_ff  <= AR_W'(area_from) * AR_W'(ssr_pkg::DAY_MINUTES);
         cp1_ff  <= 31'(slope_q14) * 31'(ssr_pkg::INV_TAN80_Q);
         pos1_ff <= POS_W'(slope_q14) * POS_W'(POS_MUL);
         thz1_ff <= slope_q14 > ssr_pkg::SLOPE_60DEG;
      end
   end

   // stage 2
   logic [POS_W-33:0] idx_raw;
   logic [IW-1:0]     idx;
   logic [15:0]       tab_a;
   logic [15:0]       tab_b;
   logic [F1_W-1:0]   f1_in;

   assign idx_raw = pos1_ff[POS_W-1:32];
   assign idx     = (idx_raw > (EXP_TABLE_DEPTH - 1)) ? IW'(EXP_TABLE_DEPTH - 1) : IW'(idx_raw);
   assign tab_a   = exp_tab[idx];
   assign tab_b   = exp_tab[idx + IW'(1)];
   assign f1_in   = (cp1_ff[30:16] > ssr_pkg::HALF_Q16) ? ssr_pkg::HALF_Q16
                                                        : F1_W'(cp1_ff[30:16]);

   logic             v2_ff;
   logic [SWE_W-1:0] swe2_ff;
   logic [WT_W-1:0]  wt2_ff;
   logic [AR_W-1:0]  ar2_ff;
   logic [F1_W-1:0]  f1_2_ff;
   logic [15:0]      a2_ff;
   logic [15:0]      ad2_ff;
   logic             dn2_ff;
   logic [15:0]      fr2_ff;
   logic             thz2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         swe2_ff <= swe1_ff;
         wt2_ff  <= wt1_ff;
         ar2_ff  <= ar1_ff;
         f1_2_ff <= f1_in;
         a2_ff   <= tab_a;
         dn2_ff  <= tab_a >= tab_b;
         ad2_ff  <= (tab_a >= tab_b) ? tab_a - tab_b : tab_b - tab_a;
         fr2_ff  <= pos1_ff[31:16];
         thz2_ff <= thz1_ff;
      end
   end

   // stage 3
   logic             v3_ff;
   logic [SWE_W-1:0] swe3_ff;
   logic [WT_W-1:0]  wt3_ff;
   logic [AR_W-1:0]  ar3_ff;
   logic [F1_W-1:0]  f1_3_ff;
   logic [15:0]      a3_ff;
   logic             dn3_ff;
   logic [31:0]      ip3_ff;
   logic             thz3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         swe3_ff <= swe2_ff;
         wt3_ff  <= wt2_ff;
         ar3_ff  <= ar2_ff;
         f1_3_ff <= f1_2_ff;
         a3_ff   <= a2_ff;
         dn3_ff  <= dn2_ff;
         ip3_ff  <= 32'(ad2_ff) * 32'(fr2_ff);
         thz3_ff <= thz2_ff;
      end
   end

   // stage 4
   logic [16:0] e_in;

   assign e_in = dn3_ff ? 17'(a3_ff) - 17'(ip3_ff[31:16]) : 17'(a3_ff) + 17'(ip3_ff[31:16]);

   logic             v4_ff;
   logic [SWE_W-1:0] swe4_ff;
   logic [WT_W-1:0]  wt4_ff;
   logic [AR_W-1:0]  ar4_ff;
   logic [F1_W-1:0]  f1_4_ff;
   logic [36:0]      thp4_ff;
   logic             thz4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         swe4_ff <= swe3_ff;
         wt4_ff  <= wt3_ff;
         ar4_ff  <= ar3_ff;
         f1_4_ff <= f1_3_ff;
         thp4_ff <= 37'(cfg.max_height) * 37'(e_in);
         thz4_ff <= thz3_ff;
      end
   end

   // threshold result, then swe / max in the divider
   logic [20:0]       thr;
   logic [SWE_W-1:0]  tmoved;
   logic [SIDE_W-1:0] div_side_in;
   logic              div_valid;
   logic [15:0]       div_quo;
   logic [SIDE_W-1:0] div_side;

   assign thr         = thz4_ff ? 21'd0 : thp4_ff[36:16];
   assign tmoved      = (21'(swe4_ff) > thr) ? SWE_W'(21'(swe4_ff) - thr) : '0;
   assign div_side_in = {tmoved, f1_4_ff, swe4_ff, wt4_ff, ar4_ff};

   ssr_div #(
      .QW(ssr_pkg::F2_QW),
      .DW(ssr_pkg::MAX_W),
      .SW(SIDE_W)
   ) u_f2_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (v4_ff),
      .in_num   ({swe4_ff, 16'd0}),
      .in_den   (cfg.max_height),
      .in_side  (div_side_in),
      .out_valid(div_valid),
      .out_quo  (div_quo),
      .out_side (div_side)
   );

   logic [SWE_W-1:0] d_tmoved;
   logic [F1_W-1:0]  d_f1;
   logic [SWE_W-1:0] d_swe;
   logic [WT_W-1:0]  d_wt;
   logic [AR_W-1:0]  d_ar;
   logic [16:0]      f2_in;

   assign {d_tmoved, d_f1, d_swe, d_wt, d_ar} = div_side;
   assign f2_in = (d_swe >= cfg.max_height) ? ssr_pkg::ONE_Q16 : {1'b0, div_quo};

   // stage after divider
   logic             v6_ff;
   logic [32:0]      p1_6_ff;
   logic [SWE_W-1:0] swe6_ff;
   logic [SWE_W-1:0] tm6_ff;
   logic [WT_W-1:0]  wt6_ff;
   logic [AR_W-1:0]  ar6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_6_ff <= 33'(d_f1) * 33'(f2_in);
         swe6_ff <= d_swe;
         tm6_ff  <= d_tmoved;
         wt6_ff  <= d_wt;
         ar6_ff  <= d_ar;
      end
   end

   // final stage
   logic [52:0]      p2;
   logic [SWE_W-1:0] moved_in;
   ssr_pkg::ssr_xfer_type xfer_ff;

   assign p2       = 53'(p1_6_ff) * 53'(swe6_ff);
   assign moved_in = cfg.method ? tm6_ff : p2[51:32];

   always_ff @(posedge clock) begin
      if (reset) begin
         xfer_ff.valid <= 1'b0;
      end else if (adv) begin
         xfer_ff.valid <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xfer_ff.moved   <= moved_in;
         xfer_ff.weight  <= wt6_ff;
         xfer_ff.area_sc <= ar6_ff;
      end
   end

   assign out_xfer = xfer_ff;

endmodule

`default_nettype wire

>>> design/ssr_rate.sv
// Exchange rate: moved * weight * area * 1440 / (32768 * timestep), saturated to 48 bits.
`default_nettype none

module ssr_rate (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         adv,
   input  wire logic [ssr_pkg::TS_W-1:0]     timestep,
   input  wire ssr_pkg::ssr_xfer_type        in_xfer,
   output logic                              out_valid,
   output logic [ssr_pkg::SWE_W-1:0]         out_moved,
   output logic [ssr_pkg::RATE_W-1:0]        out_rate,
   output logic                              out_sat
);

   localparam int SWE_W  = ssr_pkg::SWE_W;
   localparam int TS_W   = ssr_pkg::TS_W;
   localparam int RATE_W = ssr_pkg::RATE_W;
   localparam int SIDE_W = SWE_W + 1;

   // stage 1
   logic             v1_ff;
   logic [35:0]      x1_ff;
   logic [34:0]      y1_ff;
   logic [SWE_W-1:0] mv1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_xfer.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff  <= 36'(in_xfer.moved) * 36'(in_xfer.weight);
         y1_ff  <= in_xfer.area_sc;
         mv1_ff <= in_xfer.moved;
      end
   end

   // stage 2
   logic             v2_ff;
   logic [35:0]      pll_ff;
   logic [35:0]      plh_ff;
   logic [35:0]      phl_ff;
   logic [35:0]      phh_ff;
   logic [SWE_W-1:0] mv2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pll_ff <= 36'(x1_ff[17:0]) * 36'(y1_ff[17:0]);
         plh_ff <= 36'(x1_ff[17:0]) * 36'(y1_ff[34:18]);
         phl_ff <= 36'(x1_ff[35:18]) * 36'(y1_ff[17:0]);
         phh_ff <= 36'(x1_ff[35:18]) * 36'(y1_ff[34:18]);
         mv2_ff <= mv1_ff;
      end
   end

   // stage 3
   logic [70:0]      prod_in;
   logic             v3_ff;
   logic [55:0]      n3_ff;
   logic [SWE_W-1:0] mv3_ff;

   assign prod_in = 71'(pll_ff) + ((71'(plh_ff) + 71'(phl_ff)) << 18) + (71'(phh_ff) << 36);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n3_ff  <= prod_in[70:15];
         mv3_ff <= mv2_ff;
      end
   end

   // divide by the step length
   logic [TS_W-1:0]   ts_eff;
   logic              sat_in;
   logic              div_valid;
   logic [RATE_W-1:0] div_quo;
   logic [SIDE_W-1:0] div_side;

   assign ts_eff = (timestep == '0) ? TS_W'(1) : timestep;
   assign sat_in = 11'(n3_ff[55:48]) >= ts_eff;

   ssr_div #(
      .QW(RATE_W),
      .DW(TS_W),
      .SW(SIDE_W)
   ) u_rate_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (v3_ff),
      .in_num   ({3'd0, n3_ff}),
      .in_den   (ts_eff),
      .in_side  ({sat_in, mv3_ff}),
      .out_valid(div_valid),
      .out_quo  (div_quo),
      .out_side (div_side)
   );

   assign out_valid = div_valid;
   assign out_moved = div_side[SWE_W-1:0];
   assign out_sat   = div_side[SWE_W];
   assign out_rate  = div_side[SWE_W] ? '1 : div_quo;

endmodule

`default_nettype wire

>>> tb/snow_slope_redistribution_rate_tb.sv
// Self-checking testbench for the snow slope redistribution rate block.
`timescale 1ns / 100ps
`default_nettype none

module snow_slope_redistribution_rate_tb;

   localparam int LATENCY = 74;
   localparam int DEPTH   = ssr_pkg::EXP_TABLE_DEPTH;
   localparam logic [ssr_pkg::CSR_ADDR_W-1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic [ssr_pkg::SWE_W-1:0]  moved;
      logic [ssr_pkg::RATE_W-1:0] rate;
      logic                       sat;
   } transfer_type;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [ssr_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [ssr_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;
   logic                           csr_we;
   logic [ssr_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [ssr_pkg::CSR_DATA_W-1:0] csr_wdata;

   transfer_type                pending_transfers[$];
   int                          mismatch_count;
   bit                          idle_enable;
   int                          hold_off_cycles;
   logic [15:0]                 exp_lut[DEPTH+1];
   logic                        cur_method;
   logic [ssr_pkg::MAX_W-1:0]   cur_max;
   logic [ssr_pkg::TS_W-1:0]    cur_timestep;

   snow_slope_redistribution_rate u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

   // Build the exponential lookup: exp(-3 i / depth) in Q0.16.
   task automatic build_exp_lut();
      logic [63:0] step_h;
      logic [63:0] term;
      logic [63:0] ratio;
      logic [63:0] v;
      logic [63:0] t;
      step_h = (64'd3 << 32) / 64'(DEPTH);
      term = 64'd1 << 32;
      ratio = 64'd1 << 32;
      for (int k = 1; k <= 14; k++) begin
         term = ((term * step_h) >> 32) / 64'(k);
         if (k[0]) ratio = ratio - term;
         else ratio = ratio + term;
      end
      v = 64'd1 << 32;
      for (int i = 0; i <= DEPTH; i++) begin
         if (i > 0) v = (v * ratio + (64'd1 << 31)) >> 32;
         t = (v + (64'd1 << 15)) >> 16;
         exp_lut[i] = (t > 64'd65535) ? 16'hFFFF : t[15:0];
      end
   endtask

   function automatic transfer_type predict_transfer(logic [14:0] slope, logic [19:0] swe,
                                                     logic [15:0] weight, logic [23:0] area);
      transfer_type res;
      logic [63:0] f1, f2, moved, pos, idx, frac, a, b, e, thr, ts;
      logic [127:0] prod, quo;
      ts = (cur_timestep == '0) ? 64'd1 : 64'(cur_timestep);
      if (!cur_method) begin
         f1 = (64'(slope) * 64'(ssr_pkg::INV_TAN80_Q)) >> 16;
         if (f1 > 64'(ssr_pkg::HALF_Q16)) f1 = 64'(ssr_pkg::HALF_Q16);
         if (cur_max == '0 || swe >= cur_max) f2 = 64'(ssr_pkg::ONE_Q16);
         else f2 = (64'(swe) << 16) / 64'(cur_max);
         moved = (f1 * f2 * 64'(swe)) >> 32;
      end else begin
         thr = 64'd0;
         if (slope <= ssr_pkg::SLOPE_60DEG) begin
            pos = 64'(slope) * 64'(DEPTH) * 64'(ssr_pkg::INV_60DEG_Q32);
            idx = pos >> 32;
            frac = (pos >> 16) & 64'hFFFF;
            if (idx > 64'(DEPTH - 1)) idx = 64'(DEPTH - 1);
            a = 64'(exp_lut[idx]);
            b = 64'(exp_lut[idx + 64'd1]);
            e = (a >= b) ? a - (((a - b) * frac) >> 16) : a + (((b - a) * frac) >> 16);
            thr = (64'(cur_max) * e) >> 16;
         end
         moved = (64'(swe) > thr) ? 64'(swe) - thr : 64'd0;
      end
      prod = 128'(moved * 64'(weight)) * 128'(64'(area) * 64'(ssr_pkg::DAY_MINUTES));
      quo = prod / (128'd32768 * 128'(ts));
      res.moved = moved[ssr_pkg::SWE_W-1:0];
      res.sat = quo[127:48] != '0;
      res.rate = res.sat ? '1 : quo[47:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   task automatic write_csr(logic [ssr_pkg::CSR_ADDR_W-1:0] addr,
                            logic [ssr_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (addr)
         ssr_pkg::REG_METHOD:   cur_method = value[0];
         ssr_pkg::REG_MAX:      cur_max = value[ssr_pkg::MAX_W-1:0];
         ssr_pkg::REG_TIMESTEP: cur_timestep = value[ssr_pkg::TS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_request(logic [14:0] slope, logic [19:0] swe, logic [15:0] weight,
                               logic [23:0] area);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, area, weight, swe, slope};
      pending_transfers.push_back(predict_transfer(slope, swe, weight, area));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_transfers.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Response side: random stalls, long hold-off on request, and checking.
   initial begin
      transfer_type want;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
         end else if (idle_enable && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         if (rsp_tvalid && rsp_tready && !reset) begin
            if (pending_transfers.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_tdata[19:0]), 64'd0);
            end else begin
               want = pending_transfers.pop_front();
               if (rsp_tdata[19:0] !== want.moved)
                  report_mismatch("snow_moved", 64'(rsp_tdata[19:0]), 64'(want.moved));
               if (rsp_tdata[67:20] !== want.rate)
                  report_mismatch("xfer_rate", 64'(rsp_tdata[67:20]), 64'(want.rate));
               if (rsp_tuser !== want.sat)
                  report_mismatch("rate_saturated", 64'(rsp_tuser), 64'(want.sat));
            end
         end
      end
   end

   task automatic test_directed_extremes();
      write_csr(ssr_pkg::REG_METHOD, 20'd0);
      send_request(15'd0, 20'd0, 16'd0, 24'd0);
      send_request(15'h7FFF, 20'hFFFFF, 16'hFFFF, 24'hFFFFFF);
      send_request(15'd25736, 20'd1000000, 16'd32768, 24'd16777215);
      send_request(15'd12000, 20'd50000, 16'd32768, 24'd1000);
      send_request(15'd12000, 20'd150000, 16'd16384, 24'd5000);
      wait_drained();
      write_csr(ssr_pkg::REG_MAX, 20'd0);
      send_request(15'd9000, 20'd777, 16'd32768, 24'd100);
      wait_drained();
      write_csr(ssr_pkg::REG_METHOD, 20'd1);
      write_csr(ssr_pkg::REG_MAX, 20'd1000000);
      send_request(15'd0, 20'd1000000, 16'd32768, 24'd1000);
      send_request(15'd0, 20'hFFFFF, 16'hFFFF, 24'hFFFFFF);
      send_request(ssr_pkg::SLOPE_60DEG, 20'd500000, 16'd32768, 24'd2000);
      send_request(ssr_pkg::SLOPE_60DEG + 15'd1, 20'd500000, 16'd32768, 24'd2000);
      send_request(15'd25736, 20'd1000, 16'd40000, 24'd3000);
      send_request(15'd8000, 20'd10, 16'd32768, 24'd3000);
      wait_drained();
      write_csr(ssr_pkg::REG_MAX, 20'd0);
      write_csr(ssr_pkg::REG_TIMESTEP, 20'd0);
      send_request(15'd4000, 20'd1000000, 16'd65535, 24'd16777215);
      wait_drained();
      write_csr(REG_UNUSED, 20'hABCDE);
      send_request(15'd4000, 20'd12345, 16'd32768, 24'd99);
      wait_drained();
      write_csr(ssr_pkg::REG_TIMESTEP, 20'd1);
      send_request(15'd100, 20'd999999, 16'd32768, 24'd16777215);
      wait_drained();
   endtask

   task automatic send_random_burst(int count);
      logic [14:0] slope;
      for (int n = 0; n < count; n++) begin
         slope = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 25736));
         send_request(slope, ($urandom_range(0, 3) == 0) ? 20'($urandom)
                                                         : 20'($urandom_range(0, 1000000)),
                      16'($urandom), 24'($urandom));
      end
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 12; p++) begin
         write_csr(ssr_pkg::REG_METHOD, 20'(p[0]));
         write_csr(ssr_pkg::REG_MAX, (p % 3 == 0) ? 20'd1 : (p % 3 == 1) ? 20'd1000000
                                                                          : 20'($urandom));
         write_csr(ssr_pkg::REG_TIMESTEP, (p % 4 == 0) ? 20'd1440 : (p % 4 == 1) ? 20'd1
                                                                                : 20'($urandom));
         send_random_burst(100);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      write_csr(ssr_pkg::REG_METHOD, 20'd1);
      write_csr(ssr_pkg::REG_MAX, 20'd300000);
      write_csr(ssr_pkg::REG_TIMESTEP, 20'd60);
      hold_off_cycles = 300;
      send_random_burst(150);
      wait_drained();
   endtask

   task automatic test_no_idle();
      idle_enable = 0;
      write_csr(ssr_pkg::REG_METHOD, 20'd0);
      write_csr(ssr_pkg::REG_MAX, 20'd100000);
      write_csr(ssr_pkg::REG_TIMESTEP, 20'd1440);
      send_random_burst(100);
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      mismatch_count = 0;
      idle_enable = 1;
      hold_off_cycles = 0;
      cur_method = ssr_pkg::METHOD_RESET;
      cur_max = ssr_pkg::MAX_RESET;
      cur_timestep = ssr_pkg::TIMESTEP_RESET;
      build_exp_lut();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_request(15'd7000, 20'd200000, 16'd32768, 24'd500);
      wait_drained();
      test_directed_extremes();
      test_random_settings();
      test_backpressure();
      test_no_idle();
      if (mismatch_count == 0 && pending_transfers.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
+incdir+design
design/ssr_pkg.sv
design/ssr_div.sv
design/ssr_moved.sv
design/ssr_rate.sv
design/snow_slope_redistribution_rate.sv
tb/snow_slope_redistribution_rate_tb.sv
